// ----- hdl/pkmb_pkg.sv -----
// Shared constants, codes and control types for the paired key membership bitset.
// Depends on nothing; every other file of the block imports it.
package pkmb_pkg;

    localparam int NODE_BITS   = 8;
    localparam int WORD_BITS   = 8;
    localparam int SUM_BITS    = NODE_BITS + 1;
    localparam int PROD_BITS   = 2 * SUM_BITS;
    localparam int IDX_BITS    = 2 * NODE_BITS + 1;
    localparam int POS_BITS    = $clog2(WORD_BITS);
    localparam int ADDR_BITS   = IDX_BITS - POS_BITS;
    localparam int STORE_DEPTH = 2 ** ADDR_BITS;

    localparam int ACT_BITS    = 2;
    localparam int STS_BITS    = 2;
    localparam int CFG_W       = 8;
    localparam int S_FIELDS    = ACT_BITS + 2 * NODE_BITS;
    localparam int S_TDATA_W   = ((S_FIELDS + 7) / 8) * 8;
    localparam int M_FIELDS    = 1 + STS_BITS;
    localparam int M_TDATA_W   = ((M_FIELDS + 7) / 8) * 8;

    localparam logic [ACT_BITS-1:0] ACT_QUERY  = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STS_BITS-1:0] STS_OK      = 2'd0;
    localparam logic [STS_BITS-1:0] STS_RANGE   = 2'd1;
    localparam logic [STS_BITS-1:0] STS_EXISTS  = 2'd2;
    localparam logic [STS_BITS-1:0] STS_MISSING = 2'd3;

    localparam logic CFG_MAX_SOURCE = 1'b0;
    localparam logic CFG_MAX_TARGET = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_en;
        logic load_in;
        logic calc;
        logic rd;
        logic check;
        logic load_out;
    } pkmb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } pkmb_sts_t;

endpackage

// ----- hdl/pkmb_ctrl.sv -----
// Controller state machine of the paired key membership bitset.
// Depends on pkmb_pkg for the command and status types.
module pkmb_ctrl
    import pkmb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  pkmb_sts_t sts,
    output pkmb_cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_RESP  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                // Wait here only while an earlier result is still unclaimed.
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_clear_again: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_CLEAR |=> state_reg != ST_CLEAR)
        else $error("clearing pass restarted outside reset");
    a_accept_to_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> state_reg == ST_CALC)
        else $error("accepted transaction did not start the index calculation");
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result register overwritten while still holding a result");
`endif

endmodule

// ----- hdl/pkmb_datapath.sv -----
// Datapath of the paired key membership bitset: configuration, pairing arithmetic,
// the edge bit memory with its clearing counter, and the result register. Uses pkmb_pkg.
module pkmb_datapath
    import pkmb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pkmb_cmd_t            cmd,
    output pkmb_sts_t            sts,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [NODE_BITS-1:0] max_src_reg;
    logic [NODE_BITS-1:0] max_tgt_reg;
    logic [ACT_BITS-1:0]  action_reg;
    logic [NODE_BITS-1:0] src_reg;
    logic [NODE_BITS-1:0] tgt_reg;
    logic [IDX_BITS-1:0]  idx_reg;
    logic [IDX_BITS-1:0]  limit_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 res_was_reg;
    logic [STS_BITS-1:0]  res_sts_reg;
    logic                 out_was_reg;
    logic [STS_BITS-1:0]  out_sts_reg;
    logic                 m_tvalid_reg;
    logic [ADDR_BITS-1:0] clr_addr_reg;

    logic [WORD_BITS-1:0] mem [0:STORE_DEPTH-1];

    logic [SUM_BITS-1:0]  idx_sum;
    logic [SUM_BITS-1:0]  lim_sum;
    logic [PROD_BITS-1:0] idx_prod;
    logic [PROD_BITS-1:0] lim_prod;
    logic [POS_BITS-1:0]  pos;
    logic [POS_BITS-1:0]  bit_sel;
    logic [WORD_BITS-1:0] sel_mask;
    logic                 out_range;
    logic                 bit_was;
    logic                 was;
    logic [STS_BITS-1:0]  status;
    logic                 upd_we;
    logic [WORD_BITS-1:0] upd_word;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_src_reg <= '1;
            max_tgt_reg <= '1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_SOURCE: max_src_reg <= cfg_data[NODE_BITS-1:0];
                CFG_MAX_TARGET: max_tgt_reg <= cfg_data[NODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Pair index (s+t)(s+t+1)/2 + t for the request and for the configured maxima.
    assign idx_sum  = SUM_BITS'(src_reg) + SUM_BITS'(tgt_reg);
    assign lim_sum  = SUM_BITS'(max_src_reg) + SUM_BITS'(max_tgt_reg);
    assign idx_prod = PROD_BITS'(idx_sum) * (PROD_BITS'(idx_sum) + PROD_BITS'(1));
    assign lim_prod = PROD_BITS'(lim_sum) * (PROD_BITS'(lim_sum) + PROD_BITS'(1));

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg <= s_tdata[ACT_BITS-1:0];
            src_reg    <= s_tdata[ACT_BITS +: NODE_BITS];
            tgt_reg    <= s_tdata[ACT_BITS+NODE_BITS +: NODE_BITS];
        end
        if (cmd.calc) begin
            idx_reg   <= IDX_BITS'(idx_prod >> 1) + IDX_BITS'(tgt_reg);
            limit_reg <= IDX_BITS'(lim_prod >> 1) + IDX_BITS'(max_tgt_reg);
        end
        if (cmd.rd) begin
            rd_word_reg <= mem[idx_reg[IDX_BITS-1:POS_BITS]];
        end
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // The lowest index of a word sits in its most significant bit.
    assign pos       = idx_reg[POS_BITS-1:0];
    assign bit_sel   = POS_BITS'(WORD_BITS - 1) - pos;
    assign sel_mask  = WORD_BITS'(1) << bit_sel;
    assign out_range = idx_reg > limit_reg;
    assign bit_was   = rd_word_reg[bit_sel];
    assign was       = out_range ? 1'b0 : bit_was;

    always_comb begin
        status   = STS_OK;
        upd_we   = 1'b0;
        upd_word = rd_word_reg;
        if (out_range) begin
            status = STS_RANGE;
        end else begin
            case (action_reg)
                ACT_ADD: begin
                    if (bit_was) begin
                        status = STS_EXISTS;
                    end else begin
                        upd_we   = 1'b1;
                        upd_word = rd_word_reg | sel_mask;
                    end
                end
                ACT_REMOVE: begin
                    if (!bit_was) begin
                        status = STS_MISSING;
                    end else begin
                        upd_we   = 1'b1;
                        upd_word = rd_word_reg & ~sel_mask;
                    end
                end
                default: ;
            endcase
        end
    end

    assign mem_we    = cmd.clr_en || (cmd.check && upd_we);
    assign mem_waddr = cmd.clr_en ? clr_addr_reg : idx_reg[IDX_BITS-1:POS_BITS];
    assign mem_wdata = cmd.clr_en ? '0 : upd_word;

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            res_was_reg <= was;
            res_sts_reg <= status;
        end
        if (cmd.load_out) begin
            out_was_reg <= res_was_reg;
            out_sts_reg <= res_sts_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clr_en) begin
                clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.clr_last = &clr_addr_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = {(M_TDATA_W - M_FIELDS)'(0), out_sts_reg, out_was_reg};

`ifndef SYNTHESIS
    a_range_not_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_sts_reg == STS_RANGE |-> !out_was_reg)
        else $error("out of range result reports a present edge");
    a_exists_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_sts_reg == STS_EXISTS |-> out_was_reg)
        else $error("add of existing edge reported without the edge present");
    a_missing_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && out_sts_reg == STS_MISSING |-> !out_was_reg)
        else $error("remove of missing edge reported with the edge present");
`endif

endmodule

// ----- hdl/paired_key_membership_bitset.sv -----
// Paired key membership bitset: Cantor-paired edge bit store with query, add, remove.
// m_tvalid rises once the result step loads the result register, after the calc, read and check steps.
// A new transaction is accepted only after the accept, calc, read, check and result steps of the last one.
// A result that is still unclaimed holds the controller in its result step.
// Reset: aresetn is synchronous, active low; afterwards a clearing pass over all 16384 words
// zeroes the edge memory, during which no input is accepted; configuration is taken always.
module paired_key_membership_bitset
    import pkmb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // action[1:0], source_node[9:2], target_node[17:10]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // was_present[0], status[2:1]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    pkmb_cmd_t cmd;
    pkmb_sts_t sts;

    pkmb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pkmb_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
